[rtl/lpm_pkg.sv]
package lpm_pkg;

	localparam int MAX_ROWS_DEF     = 64;
	localparam int MAX_COLS_DEF     = 64;
	localparam int MAX_MONOMERS_DEF = 256;

	localparam int OP_W       = 2;
	localparam int IDX_W      = 8;
	localparam int POS_W      = 6;
	localparam int MOVE_W     = 3;
	localparam int ROWS_W     = 7;
	localparam int COLS_W     = 7;
	localparam int CHAIN_W    = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// Signed lattice coordinate, wide enough for a row or column one step past the board.
	localparam int COORD_W       = 9;
	localparam int BOND_LIMIT_SQ = 13;
	localparam int NBR_CELLS     = 9;
	localparam int NBR_W         = 4;

	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_CELL  = 2'd0;
	localparam op_t OP_POS   = 2'd1;
	localparam op_t OP_CHECK = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_ROWS  = 2'd0;
	localparam cfg_idx_t REG_COLS  = 2'd1;
	localparam cfg_idx_t REG_CHAIN = 2'd2;
	localparam cfg_idx_t REG_CYL   = 2'd3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [1:0] step_t;

	localparam step_t STEP_NEG  = 2'sb11;
	localparam step_t STEP_ZERO = 2'sb00;
	localparam step_t STEP_POS  = 2'sb01;

	typedef struct packed {
		step_t dr;
		step_t dc;
	} offset_t;

	typedef struct packed {
		logic [ROWS_W-1:0] rows;
		logic [COLS_W-1:0] cols;
		logic              cyl;
	} lattice_cfg_t;

	typedef struct packed {
		coord_t  base_row;
		coord_t  base_col;
		offset_t off;
	} coord_req_t;

	typedef struct packed {
		coord_t row;
		coord_t col;
		logic   row_ok;
		logic   col_ok;
		logic   need_rem;
	} coord_res_t;

	function automatic offset_t move_offset(input logic [MOVE_W-1:0] code);
		offset_t o;
		unique case (code)
			3'd0: o = '{STEP_NEG,  STEP_NEG};
			3'd1: o = '{STEP_NEG,  STEP_ZERO};
			3'd2: o = '{STEP_NEG,  STEP_POS};
			3'd3: o = '{STEP_ZERO, STEP_NEG};
			3'd4: o = '{STEP_ZERO, STEP_POS};
			3'd5: o = '{STEP_POS,  STEP_NEG};
			3'd6: o = '{STEP_POS,  STEP_ZERO};
			3'd7: o = '{STEP_POS,  STEP_POS};
			default: o = '{STEP_ZERO, STEP_ZERO};
		endcase
		return o;
	endfunction

	// Cells of the 3x3 neighborhood in row-major order, center included.
	function automatic offset_t nbr_offset(input logic [NBR_W-1:0] n);
		offset_t o;
		unique case (n)
			4'd0: o = '{STEP_NEG,  STEP_NEG};
			4'd1: o = '{STEP_NEG,  STEP_ZERO};
			4'd2: o = '{STEP_NEG,  STEP_POS};
			4'd3: o = '{STEP_ZERO, STEP_NEG};
			4'd4: o = '{STEP_ZERO, STEP_ZERO};
			4'd5: o = '{STEP_ZERO, STEP_POS};
			4'd6: o = '{STEP_POS,  STEP_NEG};
			4'd7: o = '{STEP_POS,  STEP_ZERO};
			4'd8: o = '{STEP_POS,  STEP_POS};
			default: o = '{STEP_ZERO, STEP_ZERO};
		endcase
		return o;
	endfunction

endpackage

[rtl/lpm_if.sv]
interface lpm_item_if;
	import lpm_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [IDX_W-1:0]    monomer_index;
	logic [POS_W-1:0]    cell_row;
	logic [POS_W-1:0]    cell_col;
	logic                occupied;
	logic [MOVE_W-1:0]   move_code;

	modport source (
		output valid, op, monomer_index, cell_row, cell_col, occupied, move_code,
		input  ready
	);
	modport sink (
		input  valid, op, monomer_index, cell_row, cell_col, occupied, move_code,
		output ready
	);
endinterface

interface lpm_result_if;
	logic valid;
	logic ready;
	logic legal;

	modport source (output valid, legal, input ready);
	modport sink (input valid, legal, output ready);
endinterface

[rtl/lattice_polymer_move_check.sv]
// Channel   Dir  Beat payload
// item      in   op, monomer_index, cell_row, cell_col, occupied, move_code
// result    out  legal (one beat per accepted check)
// cfg_*     in   write enable, register index, data (no handshake)
//
// A cell or position write leaves item.ready high. A check reads the target, then
// the nine neighborhood cells on the single occupancy read port, then the two bond
// neighbors on the position RAM port, and then loads the result. In cylinder mode
// a target row still at or beyond the row count after one wrap adds a bit-serial
// remainder step per row bit. A monomer outside the chain or a target off the
// board goes straight to the result. After reset all occupancy cells are cleared
// while item.ready stays low. A full result register holds the next check at its end.
module lattice_polymer_move_check #(
	parameter int MAX_ROWS     = lpm_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS     = lpm_pkg::MAX_COLS_DEF,
	parameter int MAX_MONOMERS = lpm_pkg::MAX_MONOMERS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lpm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lpm_pkg::CFG_DATA_W-1:0]    cfg_data,
	lpm_item_if.sink                          item,
	lpm_result_if.source                      result
);
	import lpm_pkg::*;

	localparam int OCC_DEPTH   = MAX_ROWS * MAX_COLS;
	localparam int OCC_AW      = $clog2(OCC_DEPTH);
	localparam int POS_AW      = $clog2(MAX_MONOMERS);
	localparam int RESET_ROWS  = (MAX_ROWS < 64) ? MAX_ROWS : 64;
	localparam int RESET_COLS  = (MAX_COLS < 64) ? MAX_COLS : 64;
	localparam int RESET_CHAIN = (MAX_MONOMERS < 256) ? MAX_MONOMERS : 256;
	localparam int REM_BIT_W   = $clog2(ROWS_W);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_TGT  = 6'b000010,
		ST_REM  = 6'b000100,
		ST_NBR  = 6'b001000,
		ST_BOND = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	function automatic logic [POS_AW-1:0] to_pos_addr(input logic [CHAIN_W-1:0] v);
		logic [POS_AW+CHAIN_W-1:0] w;
		w = {{POS_AW{1'b0}}, v};
		return w[POS_AW-1:0];
	endfunction

	state_t                  state_q;
	logic [ROWS_W-1:0]       rows_q;
	logic [COLS_W-1:0]       cols_q;
	logic [CHAIN_W-1:0]      chain_q;
	logic                    cyl_q;
	logic [IDX_W-1:0]        idx_q;
	logic [MOVE_W-1:0]       move_q;
	coord_t                  pr_q;
	coord_t                  pc_q;
	logic                    fail_q;
	logic [NBR_W-1:0]        nbr_q;
	logic [1:0]              bcnt_q;
	logic                    rd_chk_q;
	logic [ROWS_W-1:0]       rem_q;
	logic [ROWS_W-1:0]       rem_val_q;
	logic [REM_BIT_W-1:0]    rem_bit_q;
	logic                    out_valid_q;
	logic                    legal_q;

	logic [ROWS_W-1:0]       rows_clamp;
	logic [COLS_W-1:0]       cols_clamp;
	logic [CHAIN_W-1:0]      chain_clamp;
	lattice_cfg_t            lat_cfg;
	coord_req_t              creq;
	coord_res_t              cres;
	offset_t                 mv_off;
	offset_t                 nb_off;
	logic                    nbr_skip;
	logic                    in_acc;
	logic                    occ_busy;
	logic                    occ_we;
	logic [OCC_AW-1:0]       occ_waddr;
	logic                    occ_re;
	logic [OCC_AW-1:0]       occ_raddr;
	logic                    occ_rdata;
	logic                    pos_we;
	logic [POS_AW-1:0]       pos_waddr;
	logic                    pos_re;
	logic [POS_AW-1:0]       pos_raddr;
	logic [2*POS_W-1:0]      pos_rdata;
	logic [CHAIN_W-1:0]      idx_ext;
	logic [ROWS_W:0]         rem_shift;
	logic [ROWS_W:0]         rem_next;
	logic                    out_free;
	coord_t                  rows_c;
	coord_t                  dr_raw;
	coord_t                  dr_abs;
	coord_t                  alt_raw;
	coord_t                  alt_abs;
	coord_t                  dc_raw;
	coord_t                  dc_abs;
	logic [2:0]              dr_sat;
	logic [2:0]              dc_sat;
	logic [5:0]              bond_sq;
	logic                    bond_ok;

	// Configuration values are saturated into their legal ranges.
	always_comb begin
		rows_clamp  = cfg_data[ROWS_W-1:0];
		cols_clamp  = cfg_data[COLS_W-1:0];
		chain_clamp = cfg_data[CHAIN_W-1:0];
		if (rows_clamp == '0) begin
			rows_clamp = ROWS_W'(1);
		end else if (int'(rows_clamp) > MAX_ROWS) begin
			rows_clamp = ROWS_W'(MAX_ROWS);
		end
		if (cols_clamp == '0) begin
			cols_clamp = COLS_W'(1);
		end else if (int'(cols_clamp) > MAX_COLS) begin
			cols_clamp = COLS_W'(MAX_COLS);
		end
		if (chain_clamp == '0) begin
			chain_clamp = CHAIN_W'(1);
		end else if (int'(chain_clamp) > MAX_MONOMERS) begin
			chain_clamp = CHAIN_W'(MAX_MONOMERS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= ROWS_W'(RESET_ROWS);
			cols_q  <= COLS_W'(RESET_COLS);
			chain_q <= CHAIN_W'(RESET_CHAIN);
			cyl_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS:  rows_q  <= rows_clamp;
				REG_COLS:  cols_q  <= cols_clamp;
				REG_CHAIN: chain_q <= chain_clamp;
				REG_CYL:   cyl_q   <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	assign lat_cfg = '{rows: rows_q, cols: cols_q, cyl: cyl_q};

	assign item.ready = (state_q == ST_IDLE) && !occ_busy;
	assign in_acc     = item.valid && item.ready;
	assign idx_ext    = {1'b0, idx_q};
	assign out_free   = !out_valid_q || result.ready;

	// Shared coordinate unit: target in ST_TGT, neighborhood cells otherwise.
	always_comb begin
		mv_off = move_offset(move_q);
		nb_off = nbr_offset(nbr_q);
		if (state_q == ST_TGT) begin
			creq.base_row = $signed({{(COORD_W - POS_W){1'b0}}, pos_rdata[2*POS_W-1:POS_W]});
			creq.base_col = $signed({{(COORD_W - POS_W){1'b0}}, pos_rdata[POS_W-1:0]});
			creq.off      = mv_off;
		end else begin
			creq.base_row = pr_q;
			creq.base_col = pc_q;
			creq.off      = nb_off;
		end
		// The cell the monomer came from lies opposite the move.
		nbr_skip = (nb_off.dr == -mv_off.dr) && (nb_off.dc == -mv_off.dc);
	end

	lpm_coord_unit u_coord (
		.req (creq),
		.cfg (lat_cfg),
		.res (cres)
	);

	// Occupancy ports.
	always_comb begin
		occ_we    = in_acc && (item.op == OP_CELL) &&
			(int'(item.cell_row) < MAX_ROWS) && (int'(item.cell_col) < MAX_COLS);
		occ_waddr = OCC_AW'(item.cell_row) * OCC_AW'(MAX_COLS) + OCC_AW'(item.cell_col);
		occ_re    = (state_q == ST_NBR) && !nbr_skip && cres.row_ok && cres.col_ok;
		occ_raddr = OCC_AW'($unsigned(cres.row)) * OCC_AW'(MAX_COLS) +
			OCC_AW'($unsigned(cres.col));
	end

	lpm_occ_mem #(
		.DEPTH (OCC_DEPTH)
	) u_occ (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (occ_we),
		.waddr  (occ_waddr),
		.wdata  (item.occupied),
		.re     (occ_re),
		.raddr  (occ_raddr),
		.rdata  (occ_rdata),
		.busy   (occ_busy)
	);

	// Position ports.
	always_comb begin
		pos_we    = in_acc && (item.op == OP_POS) && (int'(item.monomer_index) < MAX_MONOMERS);
		pos_waddr = to_pos_addr({1'b0, item.monomer_index});
		pos_re    = 1'b0;
		pos_raddr = to_pos_addr({1'b0, item.monomer_index});
		priority if (state_q == ST_IDLE) begin
			pos_re = in_acc && (item.op == OP_CHECK);
		end else if ((state_q == ST_BOND) && (bcnt_q == 2'd0)) begin
			pos_re    = 1'b1;
			pos_raddr = to_pos_addr(idx_ext - CHAIN_W'(1));
		end else if ((state_q == ST_BOND) && (bcnt_q == 2'd1)) begin
			pos_re    = 1'b1;
			pos_raddr = to_pos_addr(idx_ext + CHAIN_W'(1));
		end else begin
			pos_re = 1'b0;
		end
	end

	lpm_ram #(
		.DEPTH (MAX_MONOMERS),
		.WIDTH (2 * POS_W)
	) u_pos (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata ({item.cell_row, item.cell_col}),
		.re    (pos_re),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	// Remainder step and bond length of the neighbor just read.
	always_comb begin
		rem_shift = {rem_q, rem_val_q[rem_bit_q]};
		rem_next  = (rem_shift >= {1'b0, rows_q}) ? rem_shift - {1'b0, rows_q} : rem_shift;

		rows_c  = $signed({{(COORD_W - ROWS_W){1'b0}}, rows_q});
		dr_raw  = pr_q - $signed({{(COORD_W - POS_W){1'b0}}, pos_rdata[2*POS_W-1:POS_W]});
		dr_abs  = (dr_raw < coord_t'(0)) ? -dr_raw : dr_raw;
		alt_raw = rows_c - dr_abs;
		alt_abs = (alt_raw < coord_t'(0)) ? -alt_raw : alt_raw;
		if (cyl_q && (alt_abs < dr_abs)) begin
			dr_abs = alt_abs;
		end
		dc_raw  = pc_q - $signed({{(COORD_W - POS_W){1'b0}}, pos_rdata[POS_W-1:0]});
		dc_abs  = (dc_raw < coord_t'(0)) ? -dc_raw : dc_raw;
		// Any distance of four or more already breaks the limit on its own.
		dr_sat  = (dr_abs > coord_t'(3)) ? 3'd4 : dr_abs[2:0];
		dc_sat  = (dc_abs > coord_t'(3)) ? 3'd4 : dc_abs[2:0];
		bond_sq = 6'(dr_sat) * 6'(dr_sat) + 6'(dc_sat) * 6'(dc_sat);
		bond_ok = (bond_sq <= 6'(BOND_LIMIT_SQ));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fail_q      <= 1'b0;
			nbr_q       <= '0;
			bcnt_q      <= '0;
			rd_chk_q    <= 1'b0;
			rem_bit_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_chk_q <= occ_re;
			if (rd_chk_q && occ_rdata) begin
				fail_q <= 1'b1;
			end
			// A finished check loads the result register once it is empty or its old beat leaves.
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (item.op == OP_CHECK)) begin
						if ({1'b0, item.monomer_index} >= chain_q) begin
							fail_q  <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							fail_q  <= 1'b0;
							state_q <= ST_TGT;
						end
					end
				end
				ST_TGT: begin
					nbr_q <= '0;
					if (!cres.col_ok || !cres.row_ok) begin
						fail_q  <= 1'b1;
						state_q <= ST_FIN;
					end else if (cres.need_rem) begin
						rem_bit_q <= REM_BIT_W'(ROWS_W - 1);
						state_q   <= ST_REM;
					end else begin
						state_q <= ST_NBR;
					end
				end
				ST_REM: begin
					if (rem_bit_q == '0) begin
						state_q <= ST_NBR;
					end else begin
						rem_bit_q <= rem_bit_q - REM_BIT_W'(1);
					end
				end
				ST_NBR: begin
					if (nbr_q == NBR_W'(NBR_CELLS - 1)) begin
						bcnt_q  <= '0;
						state_q <= ST_BOND;
					end else begin
						nbr_q <= nbr_q + NBR_W'(1);
					end
				end
				ST_BOND: begin
					if ((bcnt_q == 2'd1) && (idx_q != '0) && !bond_ok) begin
						fail_q <= 1'b1;
					end
					if (bcnt_q == 2'd2) begin
						if ((idx_ext != chain_q - CHAIN_W'(1)) && !bond_ok) begin
							fail_q <= 1'b1;
						end
						state_q <= ST_FIN;
					end else begin
						bcnt_q <= bcnt_q + 2'd1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q  <= item.monomer_index;
			move_q <= item.move_code;
		end
		if (state_q == ST_TGT) begin
			pr_q      <= cres.row;
			pc_q      <= cres.col;
			rem_q     <= '0;
			rem_val_q <= cres.row[ROWS_W-1:0];
		end
		if (state_q == ST_REM) begin
			rem_q <= rem_next[ROWS_W-1:0];
			if (rem_bit_q == '0) begin
				pr_q <= $signed({{(COORD_W - ROWS_W - 1){1'b0}}, rem_next});
			end
		end
		if ((state_q == ST_FIN) && out_free) begin
			legal_q <= !fail_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.legal = legal_q;
endmodule

[rtl/lpm_ram.sv]
module lpm_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 12
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/lpm_occ_mem.sv]
module lpm_occ_mem #(
	parameter int DEPTH = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic                       wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic                       rdata,
	output logic                       busy
);
	localparam int AW = $clog2(DEPTH);

	logic          mem [DEPTH];
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	// After reset every cell is swept to zero, one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= 1'b0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

	assign busy = clr_q;
endmodule

[rtl/lpm_coord_unit.sv]
module lpm_coord_unit (
	input  lpm_pkg::coord_req_t   req,
	input  lpm_pkg::lattice_cfg_t cfg,
	output lpm_pkg::coord_res_t   res
);
	import lpm_pkg::*;

	coord_t r_sum;
	coord_t c_sum;
	coord_t r_sub;
	coord_t rows_c;
	coord_t cols_c;

	always_comb begin
		rows_c = $signed({{(COORD_W - ROWS_W){1'b0}}, cfg.rows});
		cols_c = $signed({{(COORD_W - COLS_W){1'b0}}, cfg.cols});
		r_sum  = req.base_row + coord_t'(req.off.dr);
		c_sum  = req.base_col + coord_t'(req.off.dc);
		r_sub  = r_sum - rows_c;

		res.col    = c_sum;
		res.col_ok = (c_sum >= coord_t'(0)) && (c_sum < cols_c);

		res.row      = r_sum;
		res.row_ok   = 1'b1;
		res.need_rem = 1'b0;
		if (cfg.cyl) begin
			// The sum is never below -1, so a negative row wraps to the last one.
			priority if (r_sum < coord_t'(0)) begin
				res.row = rows_c - coord_t'(1);
			end else if (r_sum < rows_c) begin
				res.row = r_sum;
			end else begin
				res.row      = r_sub;
				res.need_rem = (r_sub >= rows_c);
			end
		end else begin
			res.row_ok = (r_sum >= coord_t'(0)) && (r_sum < rows_c);
		end
	end
endmodule

[rtl/lpm_checker.sv]
module lpm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [lpm_pkg::OP_W-1:0]   in_op,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       out_legal
);
	import lpm_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// A check keeps the block busy after its beat.
	a_check_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_op == OP_CHECK) |=> !in_ready)
		else $error("block ready right after a check beat");

	// Writes and unknown ops leave the input side open.
	a_write_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_op != OP_CHECK) |=> in_ready)
		else $error("block not ready after a write beat");

	// A check never answers in the cycle after its beat.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_op == OP_CHECK) && !out_valid |=> !out_valid)
		else $error("result appeared one cycle after a check beat");

	// A new result is loaded as the sequencer returns to idle.
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while the block is busy");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_legal))
		else $error("stalled result beat changed");
endmodule

bind lattice_polymer_move_check lpm_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.in_op     (item.op),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_legal (result.legal)
);

[tb/sv/tb_lattice_polymer_move_check.sv]
`timescale 1ns / 1ps

module tb_lattice_polymer_move_check;
	import lpm_pkg::*;

	localparam op_t OP_NONE = 2'd3;

	localparam logic [1:0] WANT_ILLEGAL   = 2'd0;
	localparam logic [1:0] WANT_LEGAL     = 2'd1;
	localparam logic [1:0] WANT_PREDICTED = 2'd2;

	localparam int DRAIN_CYCLES = 40;
	localparam int FIRST_ITEMS  = 220;
	localparam int NUM_PHASES   = 6;
	localparam int LIMIT_NS     = 8000000;

	localparam int MOVE_DR [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
	localparam int MOVE_DC [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};

	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  idx;
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
		logic              occ;
		logic [MOVE_W-1:0] mv;
		logic [1:0]        want;
	} stim_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] rows;
		logic [CFG_DATA_W-1:0] cols;
		logic [CFG_DATA_W-1:0] chain;
		logic [CFG_DATA_W-1:0] cyl;
		int                    items;
	} phase_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

	// Directed rows assume the serpentine chain laid down after reset with the
	// default 64x64 flat board.
	localparam stim_t DIRECTED [24] = '{
		'{OP_CHECK, 8'd0,   6'd0,  6'd0,  1'b0, 3'd0, WANT_ILLEGAL},
		'{OP_CHECK, 8'd0,   6'd0,  6'd0,  1'b0, 3'd2, WANT_ILLEGAL},
		'{OP_CELL,  8'd0,   6'd0,  6'd2,  1'b1, 3'd0, WANT_PREDICTED},
		'{OP_CHECK, 8'd0,   6'd0,  6'd0,  1'b0, 3'd4, WANT_ILLEGAL},
		'{OP_CELL,  8'd0,   6'd0,  6'd2,  1'b0, 3'd0, WANT_PREDICTED},
		'{OP_CELL,  8'd0,   6'd1,  6'd3,  1'b1, 3'd0, WANT_PREDICTED},
		'{OP_CHECK, 8'd0,   6'd0,  6'd0,  1'b0, 3'd4, WANT_ILLEGAL},
		'{OP_CELL,  8'd0,   6'd1,  6'd3,  1'b0, 3'd0, WANT_PREDICTED},
		'{OP_CELL,  8'd0,   6'd0,  6'd1,  1'b1, 3'd0, WANT_PREDICTED},
		'{OP_CHECK, 8'd0,   6'd0,  6'd0,  1'b0, 3'd4, WANT_PREDICTED},
		'{OP_CELL,  8'd0,   6'd0,  6'd1,  1'b0, 3'd0, WANT_PREDICTED},
		'{OP_POS,   8'd255, 6'd63, 6'd63, 1'b0, 3'd0, WANT_PREDICTED},
		'{OP_CHECK, 8'd255, 6'd0,  6'd0,  1'b0, 3'd7, WANT_ILLEGAL},
		'{OP_CHECK, 8'd255, 6'd0,  6'd0,  1'b0, 3'd0, WANT_ILLEGAL},
		'{OP_CELL,  8'd0,   6'd63, 6'd63, 1'b1, 3'd0, WANT_PREDICTED},
		'{OP_CHECK, 8'd255, 6'd0,  6'd0,  1'b0, 3'd3, WANT_PREDICTED},
		'{OP_CELL,  8'd0,   6'd63, 6'd63, 1'b0, 3'd0, WANT_PREDICTED},
		'{OP_NONE,  8'd255, 6'd63, 6'd63, 1'b1, 3'd7, WANT_PREDICTED},
		'{OP_POS,   8'd255, 6'd30, 6'd1,  1'b0, 3'd0, WANT_PREDICTED},
		'{OP_CHECK, 8'd255, 6'd0,  6'd0,  1'b0, 3'd3, WANT_PREDICTED},
		'{OP_CHECK, 8'd128, 6'd0,  6'd0,  1'b0, 3'd6, WANT_PREDICTED},
		'{OP_NONE,  8'd0,   6'd0,  6'd0,  1'b0, 3'd0, WANT_PREDICTED},
		'{OP_CHECK, 8'd17,  6'd0,  6'd0,  1'b0, 3'd5, WANT_PREDICTED},
		'{OP_CHECK, 8'd0,   6'd0,  6'd0,  1'b0, 3'd5, WANT_PREDICTED}
	};

	// Register values include zero and values above the range, which saturate.
	localparam phase_t PHASES [NUM_PHASES] = '{
		'{9'h1FF, 9'd20,  9'd0,   9'd1, 150},
		'{9'd1,   9'd1,   9'h1FF, 9'd0, 100},
		'{9'd3,   9'd64,  9'd100, 9'd1, 300},
		'{9'd40,  9'd33,  9'd200, 9'd0, 300},
		'{9'h1C0, 9'h07F, 9'd256, 9'd1, 350},
		'{9'd0,   9'd0,   9'd300, 9'd1, 100}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lpm_item_if   item_ch ();
	lpm_result_if result_ch ();

	lattice_polymer_move_check dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	// Shadow copy of the block state.
	bit occ_map [MAX_ROWS_DEF][MAX_COLS_DEF];
	int mono_r [MAX_MONOMERS_DEF];
	int mono_c [MAX_MONOMERS_DEF];
	int rows_n  = MAX_ROWS_DEF;
	int cols_n  = MAX_COLS_DEF;
	int chain_n = MAX_MONOMERS_DEF;
	bit cyl     = 1'b0;

	logic legal_q [$];
	int   errors = 0;
	int   burst_left = 1;
	logic legal_want;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int clamp_cfg(int v, int hi);
		return (v < 1) ? 1 : ((v > hi) ? hi : v);
	endfunction

	function automatic int fold_row(int r);
		int m;
		m = r % rows_n;
		return (m < 0) ? m + rows_n : m;
	endfunction

	function automatic bit bond_fits(int tr, int tc, int other);
		int dr;
		int dc;
		int alt;
		dr = tr - mono_r[other];
		if (dr < 0) dr = -dr;
		dc = tc - mono_c[other];
		if (cyl) begin
			alt = rows_n - dr;
			if (alt < 0) alt = -alt;
			if (alt < dr) dr = alt;
		end
		return (dr * dr + dc * dc) <= BOND_LIMIT_SQ;
	endfunction

	function automatic logic legal_move(int idx, logic [MOVE_W-1:0] code);
		int dr;
		int dc;
		int tr;
		int tc;
		int r;
		int c;
		if (idx >= chain_n) return 1'b0;
		dr = MOVE_DR[code];
		dc = MOVE_DC[code];
		tr = mono_r[idx] + dr;
		tc = mono_c[idx] + dc;
		if (cyl) begin
			tr = fold_row(tr);
		end else if (tr < 0 || tr >= rows_n) begin
			return 1'b0;
		end
		if (tc < 0 || tc >= cols_n) return 1'b0;
		if (occ_map[tr][tc]) return 1'b0;
		for (int i = -1; i <= 1; i++) begin
			for (int j = -1; j <= 1; j++) begin
				// The cell the monomer leaves does not block its own move.
				if (i == -dr && j == -dc) continue;
				r = tr + i;
				c = tc + j;
				if (c < 0 || c >= cols_n) continue;
				if (cyl) begin
					r = fold_row(r);
				end else if (r < 0 || r >= rows_n) begin
					continue;
				end
				if (occ_map[r][c]) return 1'b0;
			end
		end
		if (idx != 0 && !bond_fits(tr, tc, idx - 1)) return 1'b0;
		if (idx != chain_n - 1 && !bond_fits(tr, tc, idx + 1)) return 1'b0;
		return 1'b1;
	endfunction

	function automatic stim_t random_item();
		stim_t s;
		int    pick;
		int    sub;
		int    nb;
		int    d;
		s.op   = OP_NONE;
		s.idx  = IDX_W'($urandom_range(0, MAX_MONOMERS_DEF - 1));
		s.row  = POS_W'($urandom_range(0, 63));
		s.col  = POS_W'($urandom_range(0, 63));
		s.occ  = ($urandom_range(0, 1) == 1);
		s.mv   = MOVE_W'($urandom_range(0, 7));
		s.want = WANT_PREDICTED;
		pick = $urandom_range(0, 99);
		sub  = $urandom_range(0, 9);
		if (pick < 45) begin
			s.op = OP_CHECK;
			if (pick < 38) s.idx = IDX_W'($urandom_range(0, chain_n - 1));
		end else if (pick < 70) begin
			s.op = OP_POS;
			if (sub < 4) begin
				// Place the monomer within a bond or two of a chain neighbor.
				if (s.idx == 0) nb = 1;
				else if (s.idx == MAX_MONOMERS_DEF - 1) nb = s.idx - 1;
				else nb = ($urandom_range(0, 1) == 1) ? s.idx + 1 : s.idx - 1;
				d = $urandom_range(0, 4);
				s.row = POS_W'(mono_r[nb] + d - 2);
				d = $urandom_range(0, 4);
				s.col = POS_W'(mono_c[nb] + d - 2);
			end else if (sub < 7) begin
				s.row = POS_W'($urandom_range(0, rows_n - 1));
				s.col = POS_W'($urandom_range(0, cols_n - 1));
			end
		end else if (pick < 95) begin
			s.op  = OP_CELL;
			s.occ = ($urandom_range(0, 3) == 0);
			if (sub < 5) begin
				nb = $urandom_range(0, MAX_MONOMERS_DEF - 1);
				d = $urandom_range(0, 4);
				s.row = POS_W'(mono_r[nb] + d - 2);
				d = $urandom_range(0, 4);
				s.col = POS_W'(mono_c[nb] + d - 2);
			end
		end
		return s;
	endfunction

	// Called at a falling edge; returns at a falling edge after the beat is taken.
	task automatic send_item(input stim_t s);
		item_ch.valid         <= 1'b1;
		item_ch.op            <= s.op;
		item_ch.monomer_index <= s.idx;
		item_ch.cell_row      <= s.row;
		item_ch.cell_col      <= s.col;
		item_ch.occupied      <= s.occ;
		item_ch.move_code     <= s.mv;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		case (s.op)
			OP_CELL: occ_map[s.row][s.col] = s.occ;
			OP_POS: begin
				mono_r[s.idx] = s.row;
				mono_c[s.idx] = s.col;
			end
			OP_CHECK: begin
				if (s.want == WANT_PREDICTED) legal_q.push_back(legal_move(int'(s.idx), s.mv));
				else legal_q.push_back(s.want == WANT_LEGAL);
			end
			default: ;
		endcase
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(40, 120);
			else burst_left = $urandom_range(1, 16);
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_ROWS:  rows_n  = clamp_cfg(int'(data[ROWS_W-1:0]), MAX_ROWS_DEF);
			REG_COLS:  cols_n  = clamp_cfg(int'(data[COLS_W-1:0]), MAX_COLS_DEF);
			REG_CHAIN: chain_n = clamp_cfg(int'(data[CHAIN_W-1:0]), MAX_MONOMERS_DEF);
			default:   cyl     = data[0];
		endcase
		@(negedge clk);
	endtask

	// Wait for every outstanding check, then give a write time to retire.
	task automatic settle();
		while (legal_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (legal_q.size() == 0) begin
				$error("legal: beat with no check outstanding, actual %0b", result_ch.legal);
				errors++;
			end else begin
				legal_want = legal_q.pop_front();
				if (result_ch.legal !== legal_want) begin
					$error("legal: expected %0b, actual %0b", legal_want, result_ch.legal);
					errors++;
				end
			end
		end
	end

	initial begin
		rx_mode_t mode;
		int       left;
		result_ch.ready = 1'b0;
		mode = RX_OPEN;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				left = $urandom_range(8, 64);
			end
			left--;
			case (mode)
				RX_OPEN:   result_ch.ready <= 1'b1;
				RX_COIN:   result_ch.ready <= ($urandom_range(0, 1) == 1);
				RX_SPARSE: result_ch.ready <= ($urandom_range(0, 4) == 0);
				default:   result_ch.ready <= ((left % 12) < 3);
			endcase
		end
	end

	initial begin
		stim_t s;
		int    band;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = REG_ROWS;
		cfg_data              = '0;
		item_ch.valid         = 1'b0;
		item_ch.op            = OP_CELL;
		item_ch.monomer_index = '0;
		item_ch.cell_row      = '0;
		item_ch.cell_col      = '0;
		item_ch.occupied      = 1'b0;
		item_ch.move_code     = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		burst_left = $urandom_range(1, 16);

		// Serpentine chain, neighbors two cells apart. Every position
		// is written before any check can read it.
		for (int k = 0; k < MAX_MONOMERS_DEF; k++) begin
			band   = k / 16;
			s.op   = OP_POS;
			s.idx  = IDX_W'(k);
			s.row  = POS_W'(2 * band);
			s.col  = POS_W'((band % 2 == 0) ? 2 * (k % 16) + 1 : 2 * (15 - k % 16) + 1);
			s.occ  = ($urandom_range(0, 1) == 1);
			s.mv   = MOVE_W'($urandom_range(0, 7));
			s.want = WANT_PREDICTED;
			send_item(s);
		end

		foreach (DIRECTED[k]) send_item(DIRECTED[k]);
		for (int n = 0; n < FIRST_ITEMS; n++) send_item(random_item());

		for (int p = 0; p < NUM_PHASES; p++) begin
			item_ch.valid <= 1'b0;
			settle();
			write_reg(REG_ROWS, PHASES[p].rows);
			write_reg(REG_COLS, PHASES[p].cols);
			write_reg(REG_CHAIN, PHASES[p].chain);
			write_reg(REG_CYL, PHASES[p].cyl);
			cfg_we <= 1'b0;
			for (int n = 0; n < PHASES[p].items; n++) send_item(random_item());
		end

		item_ch.valid <= 1'b0;
		settle();
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#LIMIT_NS;
		$display("Test completed with failures");
		$finish;
	end

endmodule

[files.f]
rtl/lpm_pkg.sv
rtl/lpm_if.sv
rtl/lpm_ram.sv
rtl/lpm_occ_mem.sv
rtl/lpm_coord_unit.sv
rtl/lattice_polymer_move_check.sv
rtl/lpm_checker.sv
tb/sv/tb_lattice_polymer_move_check.sv
